// ===== rtl/core/b64sd_pkg.sv =====
package b64sd_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3d;
  localparam int unsigned GROUP_W = 24;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  typedef struct packed {
    logic [GROUP_W-1:0] bits;
    logic [1:0]         nbytes;
  } burst_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      s.value = 6'd62;
    end else if (c == 8'h2f) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// base64 stream decoder, standard alphabet with '=' padding
// input channel: one character per request in in_tdata, in_tlast marks the
// final character of the stream; a partial group is flushed after it
// output channel: one decoded byte per request in out_tdata, out_tlast set
// on the last byte produced by one input character
// characters outside the alphabet and other than '=' are dropped
// the group state updates in the accepting cycle; a finished group is
// registered in the queue; its first byte goes out on out_tdata at the head
// throughput: one character per cycle; each finished group goes into a
// two-entry queue of up to three bytes that drains one byte per cycle while
// out_tready is high, so input stalls only when both entries are occupied
// reset clears the group state and empties the queue
// when the receiver stalls the current byte holds and the queue fills, then
// in_tready drops until an entry drains
module base64_stream_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_in
  input  logic       in_tlast,   // end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // byte_out
  output logic       out_tlast   // last_of_run
);
  import b64sd_pkg::*;

  logic [GROUP_W-1:0] bits_r, bits_nxt;
  logic [1:0]         pos_r, pos_nxt;
  logic [2:0]         dcnt_r, dcnt_nxt;
  logic               pad_r, pad_nxt;

  burst_t             queue_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [1:0]         idx_r, idx_nxt;

  sextet_t            sx;
  logic               is_pad, in_fire, out_fire, push, pop, emit;
  logic [GROUP_W-1:0] gbits;
  logic [1:0]         gpos;
  logic [2:0]         gd;
  logic               gpad;
  logic [1:0]         nbytes;
  burst_t             head;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign sx       = sextet_of(in_tdata);
  assign is_pad   = (in_tdata == PAD_CHAR);

  always_comb begin
    gbits = bits_r;
    gd    = dcnt_r;
    gpad  = pad_r;
    gpos  = pos_r;
    emit  = 1'b0;
    if (sx.valid || is_pad) begin
      if (is_pad) begin
        gpad = 1'b1;
      end else if (!pad_r) begin
        case (pos_r)
          2'd0: gbits[23:18] = sx.value;
          2'd1: gbits[17:12] = sx.value;
          2'd2: gbits[11:6]  = sx.value;
          default: gbits[5:0] = sx.value;
        endcase
        gd = dcnt_r + 3'd1;
      end
      if (pos_r == 2'd3) begin
        emit = 1'b1;
      end else begin
        gpos = pos_r + 2'd1;
      end
    end
    if (in_tlast && (gpos != 2'd0 || gpad || gd != 3'd0)) begin
      emit = 1'b1;
    end
    if (gd >= 3'd4) begin
      nbytes = 2'd3;
    end else if (gd >= 3'd1) begin
      nbytes = 2'(gd - 3'd1);
    end else begin
      nbytes = 2'd0;
    end
    bits_nxt = gbits;
    pos_nxt  = gpos;
    dcnt_nxt = gd;
    pad_nxt  = gpad;
    if (emit) begin
      bits_nxt = '0;
      pos_nxt  = 2'd0;
      dcnt_nxt = 3'd0;
      pad_nxt  = 1'b0;
    end
  end

  assign push      = in_fire && emit && (nbytes != 2'd0);
  assign in_tready = (cnt_r != 2'd2);

  assign head       = queue_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = (idx_r == head.nbytes - 2'd1);
  assign pop        = out_fire && out_tlast;

  always_comb begin
    case (idx_r)
      2'd0:    out_tdata = head.bits[23:16];
      2'd1:    out_tdata = head.bits[15:8];
      default: out_tdata = head.bits[7:0];
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= '0;
      pos_r    <= 2'd0;
      dcnt_r   <= 3'd0;
      pad_r    <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      if (in_fire) begin
        bits_r <= bits_nxt;
        pos_r  <= pos_nxt;
        dcnt_r <= dcnt_nxt;
        pad_r  <= pad_nxt;
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{bits: gbits, nbytes: nbytes};
    end
  end

  // queue occupancy stays within its two entries
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  // a shown byte always lies inside the head burst
  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (head.nbytes != 2'd0 && idx_r < head.nbytes))
    else $error("byte index outside burst");

  // pointers and count agree
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers inconsistent with count");

  // data characters never exceed one group
  a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= {1'b0, pos_r})
    else $error("data count exceeds group position");

endmodule
